// ===== src/radar_measurement_jacobian_top_defines.svh =====
// assertion macros for the radar measurement jacobian block
// expects i_clk and i_rst_n in the scope of each use
`ifndef RADAR_MEASUREMENT_JACOBIAN_TOP_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RMJ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmj check failed");
`define RMJ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmj check failed");
`else
`define RMJ_ASSERT_IMP(name, ante, cons)
`define RMJ_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== src/rmj_pkg.sv =====
// shared widths and stage types for the radar measurement jacobian
// no dependencies
`default_nettype none
package rmj_pkg;
    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned MAG_W    = 32;
    localparam int unsigned C_W      = 64;
    localparam int unsigned ROOT_W   = 64;
    localparam int unsigned REM_W    = 66;
    localparam int unsigned SQ_STEPS = 64;
    localparam int unsigned QB       = 33;  // quotient bits kept before the overflow flag
    localparam int unsigned N_IN     = 4;
    localparam int unsigned N_OUT    = 6;
    localparam int unsigned TUSER_W  = 2;
    localparam int unsigned TU_ZERO  = 0;
    localparam int unsigned TU_SAT   = 1;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [C_W-1:0]    rad;
        logic [C_W-1:0]    c;
    } t_sqrt_stage;

    typedef struct packed {
        logic nx;
        logic ny;
        logic sw;
        logic zero;
    } t_flags;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [C_W-1:0]   mw;
        t_flags           fl;
    } t_side;
endpackage
`default_nettype wire

// ===== src/rmj_sqrt_cell.sv =====
// one digit step of the square root chain, two radicand bits per cell
// depends on rmj_pkg
`default_nettype none
module rmj_sqrt_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire rmj_pkg::t_sqrt_stage i_st,
    output rmj_pkg::t_sqrt_stage      o_st
);
    import rmj_pkg::*;

    logic [REM_W+1:0] w_rem4;
    logic [REM_W+1:0] w_trial;
    t_sqrt_stage      n_st;
    t_sqrt_stage      r_st;

    always_comb begin
        w_rem4  = {i_st.rem, i_st.rad[C_W-1 -: 2]};
        w_trial = {2'b00, i_st.root, 2'b01};
        n_st.rad = i_st.rad << 2;
        n_st.c   = i_st.c;
        if (w_rem4 >= w_trial) begin
            n_st.rem  = REM_W'(w_rem4 - w_trial);
            n_st.root = {i_st.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_st.rem  = REM_W'(w_rem4);
            n_st.root = {i_st.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule
`default_nettype wire

// ===== src/rmj_div_cell.sv =====
// one restoring division step, decides quotient bit SHIFT
// depends on rmj_pkg
`default_nettype none
module rmj_div_cell #(
    parameter int unsigned DEN_W = 64,
    parameter int unsigned SHIFT = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [DEN_W+rmj_pkg::QB-1:0] i_rem,
    input  wire logic [DEN_W-1:0]            i_den,
    input  wire logic [rmj_pkg::QB-1:0]      i_quo,
    input  wire logic                        i_ovf,
    output logic [DEN_W+rmj_pkg::QB-1:0]     o_rem,
    output logic [DEN_W-1:0]                 o_den,
    output logic [rmj_pkg::QB-1:0]           o_quo,
    output logic                             o_ovf
);
    import rmj_pkg::*;
    localparam int unsigned DIV_W = DEN_W + QB;

    logic [DIV_W-1:0] w_sub;
    logic [DIV_W-1:0] n_rem;
    logic [QB-1:0]    n_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QB-1:0]    r_quo;
    logic             r_ovf;

    always_comb begin
        w_sub = DIV_W'(i_den) << SHIFT;
        if (i_rem >= w_sub) begin
            n_rem = i_rem - w_sub;
            n_quo = i_quo | (QB'(1) << SHIFT);
        end else begin
            n_rem = i_rem;
            n_quo = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
            r_ovf <= i_ovf;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ovf = r_ovf;
endmodule
`default_nettype wire

// ===== src/rmj_div_chain.sv =====
// pipelined divider: overflow check stage then one cell per quotient bit
// depends on rmj_pkg and rmj_div_cell
`default_nettype none
module rmj_div_chain #(
    parameter int unsigned DEN_W = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [DEN_W+rmj_pkg::QB-1:0] i_num,
    input  wire logic [DEN_W-1:0]             i_den,
    output logic [rmj_pkg::QB-1:0]            o_quo,
    output logic                              o_ovf
);
    import rmj_pkg::*;
    localparam int unsigned DIV_W = DEN_W + QB;

    logic [DIV_W-1:0] w_rem [0:QB];
    logic [DEN_W-1:0] w_den [0:QB];
    logic [QB-1:0]    w_quo [0:QB];
    logic             w_ovf [0:QB];
    logic [DIV_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_ovf;

    // quotient too large for the kept bits: result saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_ovf <= (i_num >= {i_den, {QB{1'b0}}});
        end
    end

    assign w_rem[0] = r_rem;
    assign w_den[0] = r_den;
    assign w_quo[0] = '0;
    assign w_ovf[0] = r_ovf;

    for (genvar g = 0; g < QB; g++) begin : g_cell
        rmj_div_cell #(
            .DEN_W (DEN_W),
            .SHIFT (QB - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[g]),
            .i_den (w_den[g]),
            .i_quo (w_quo[g]),
            .i_ovf (w_ovf[g]),
            .o_rem (w_rem[g+1]),
            .o_den (w_den[g+1]),
            .o_quo (w_quo[g+1]),
            .o_ovf (w_ovf[g+1])
        );
    end

    assign o_quo = w_quo[QB];
    assign o_ovf = w_ovf[QB];
endmodule
`default_nettype wire

// ===== src/radar_measurement_jacobian_top.sv =====
// radar measurement jacobian, fully pipelined; depends on rmj_pkg and the cell chains
// throughput: one request per cycle; the pipeline holds the 64-cell square root chain
// and the 34-stage divider chains; a stalled output freezes the whole pipeline
// reset: synchronous active-low i_rst_n clears the valid pipeline only
`default_nettype none
`include "radar_measurement_jacobian_top_defines.svh"
module radar_measurement_jacobian_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_s_axis_tvalid,
    output logic                                          o_s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y from bit 0 up
    input  wire logic [rmj_pkg::N_IN*rmj_pkg::FIELD_W-1:0] i_s_axis_tdata,
    output logic                                          o_m_axis_tvalid,
    input  wire logic                                     i_m_axis_tready,
    // range_by_px, range_by_py, bearing_by_px, bearing_by_py, rate_by_px, rate_by_py
    output logic [rmj_pkg::N_OUT*rmj_pkg::FIELD_W-1:0]    o_m_axis_tdata,
    // zero_range, saturated from bit 0 up
    output logic [rmj_pkg::TUSER_W-1:0]                   o_m_axis_tuser
);
    import rmj_pkg::*;

    localparam int unsigned LAT     = 3 + SQ_STEPS + 2 + (QB + 1) + 1;
    localparam int unsigned V_SQ    = 2 + SQ_STEPS;
    localparam int unsigned V_DIV   = LAT - 2;
    localparam int unsigned NUM_W   = C_W + QB;
    localparam int unsigned DEN3_W  = 2 * C_W;
    localparam int unsigned TNUM_W  = DEN3_W + QB;
    localparam int unsigned NY_W    = MAG_W + C_W;
    localparam int unsigned RSH     = 32 + FRAC_BITS;
    localparam int unsigned BSH     = 2 * FRAC_BITS;
    localparam int unsigned E_RPX   = 0;
    localparam int unsigned E_RPY   = 1;
    localparam int unsigned E_BPX   = 2;
    localparam int unsigned E_BPY   = 3;
    localparam int unsigned E_TPX   = 4;
    localparam int unsigned E_TPY   = 5;
    localparam logic [QB-1:0] NEG_LIM = QB'(64'h8000_0000);
    localparam logic [QB-1:0] POS_LIM = QB'(64'h7FFF_FFFF);
    localparam logic signed [FIELD_W-1:0] RNG_ONE = $signed(FIELD_W'(1) << FRAC_BITS);

    function automatic logic [C_W-1:0] f_mul32(input logic [MAG_W-1:0] a,
                                               input logic [MAG_W-1:0] b);
        return {{(C_W-MAG_W){1'b0}}, a} * {{(C_W-MAG_W){1'b0}}, b};
    endfunction

    function automatic logic [MAG_W-1:0] f_mag(input logic [FIELD_W-1:0] v);
        return v[FIELD_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    // returns {clipped, value}
    function automatic logic [FIELD_W:0] f_pack(input logic neg, input logic [QB-1:0] quo,
                                                input logic ovf);
        logic [FIELD_W-1:0] val;
        logic               sat;
        if (neg) begin
            sat = ovf || (quo > NEG_LIM);
            val = sat ? FIELD_W'(NEG_LIM) : FIELD_W'(QB'(0) - quo);
        end else begin
            sat = ovf || (quo > POS_LIM);
            val = sat ? FIELD_W'(POS_LIM) : FIELD_W'(quo);
        end
        return {sat, val};
    endfunction

    logic               w_en;
    logic               w_acc;
    logic [LAT-1:0]     r_vld;

    // stage 1: sign and magnitude
    logic [MAG_W-1:0] r1_ax, r1_ay, r1_avx, r1_avy;
    logic             r1_nx, r1_ny, r1_nvx, r1_nvy, r1_zero;
    // stage 2: squares and cross products
    logic [C_W-1:0]   r2_ax2, r2_ay2, r2_ma, r2_mb;
    logic [MAG_W-1:0] r2_ax, r2_ay;
    logic             r2_nx, r2_ny, r2_sa, r2_sb, r2_zero;
    // stage 3 and the side line through the root chain
    logic [C_W-1:0]   r3_c;
    t_side            n_side;
    t_side            r_sd [0:SQ_STEPS];
    t_sqrt_stage      w_sq [0:SQ_STEPS];
    logic [REM_W-1:0] w_root2;
    // stage 4: partial products
    logic [C_W-1:0]   r4_p00, r4_p01, r4_p10, r4_p11, r4_y0, r4_y1, r4_x0, r4_x1;
    logic [C_W-1:0]   r4_c, r4_s;
    logic [MAG_W-1:0] r4_ax, r4_ay;
    t_flags           r4_fl;
    // stage 5: summed products
    logic [DEN3_W-1:0] r5_den3;
    logic [NY_W-1:0]   r5_ny, r5_nx;
    logic [C_W-1:0]    r5_c, r5_s;
    logic [MAG_W-1:0]  r5_ax, r5_ay;
    t_flags            r5_fl;
    t_flags            r_fl [0:QB];
    // dividers
    logic [NUM_W-1:0]  w_num_rpx, w_num_rpy, w_num_bpx, w_num_bpy;
    logic [TNUM_W-1:0] w_num_tpx, w_num_tpy;
    logic [QB-1:0]     w_quo [0:N_OUT-1];
    logic              w_ovf [0:N_OUT-1];
    logic              w_neg [0:N_OUT-1];
    logic              w_any_ovf;
    logic [FIELD_W:0]  w_pk [0:N_OUT-1];
    logic [N_OUT*FIELD_W-1:0] n_out_data;
    logic              n_sat;
    logic [N_OUT*FIELD_W-1:0] r_out_data;
    logic [TUSER_W-1:0] r_out_user;
    logic signed [FIELD_W-1:0] w_rng_px;

    assign w_en            = !r_vld[LAT-1] || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax   <= f_mag(i_s_axis_tdata[0*FIELD_W +: FIELD_W]);
            r1_ay   <= f_mag(i_s_axis_tdata[1*FIELD_W +: FIELD_W]);
            r1_avx  <= f_mag(i_s_axis_tdata[2*FIELD_W +: FIELD_W]);
            r1_avy  <= f_mag(i_s_axis_tdata[3*FIELD_W +: FIELD_W]);
            r1_nx   <= i_s_axis_tdata[1*FIELD_W-1];
            r1_ny   <= i_s_axis_tdata[2*FIELD_W-1];
            r1_nvx  <= i_s_axis_tdata[3*FIELD_W-1];
            r1_nvy  <= i_s_axis_tdata[4*FIELD_W-1];
            r1_zero <= (i_s_axis_tdata[2*FIELD_W-1:0] == '0);

            r2_ax2  <= f_mul32(r1_ax, r1_ax);
            r2_ay2  <= f_mul32(r1_ay, r1_ay);
            r2_ma   <= f_mul32(r1_avx, r1_ay);
            r2_mb   <= f_mul32(r1_avy, r1_ax);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_nx   <= r1_nx;
            r2_ny   <= r1_ny;
            r2_sa   <= r1_nvx ^ r1_ny;
            r2_sb   <= r1_nvy ^ r1_nx;
            r2_zero <= r1_zero;

            r3_c    <= r2_ax2 + r2_ay2;
            r_sd[0] <= n_side;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // w = vx*py - vy*px as sign and magnitude
    always_comb begin
        n_side.ax      = r2_ax;
        n_side.ay      = r2_ay;
        n_side.fl.nx   = r2_nx;
        n_side.fl.ny   = r2_ny;
        n_side.fl.zero = r2_zero;
        if (r2_sa != r2_sb) begin
            n_side.mw    = r2_ma + r2_mb;
            n_side.fl.sw = r2_sa;
        end else if (r2_ma >= r2_mb) begin
            n_side.mw    = r2_ma - r2_mb;
            n_side.fl.sw = r2_sa;
        end else begin
            n_side.mw    = r2_mb - r2_ma;
            n_side.fl.sw = !r2_sa;
        end
    end

    assign w_sq[0] = '{rem: '0, root: '0, rad: r3_c, c: r3_c};

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        rmj_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_st  (w_sq[g]),
            .o_st  (w_sq[g+1])
        );
    end

    assign w_root2 = REM_W'({w_sq[SQ_STEPS].root, 1'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_p00 <= f_mul32(w_sq[SQ_STEPS].c[MAG_W-1:0], w_sq[SQ_STEPS].root[MAG_W-1:0]);
            r4_p01 <= f_mul32(w_sq[SQ_STEPS].c[MAG_W-1:0], w_sq[SQ_STEPS].root[C_W-1:MAG_W]);
            r4_p10 <= f_mul32(w_sq[SQ_STEPS].c[C_W-1:MAG_W], w_sq[SQ_STEPS].root[MAG_W-1:0]);
            r4_p11 <= f_mul32(w_sq[SQ_STEPS].c[C_W-1:MAG_W], w_sq[SQ_STEPS].root[C_W-1:MAG_W]);
            r4_y0  <= f_mul32(r_sd[SQ_STEPS].ay, r_sd[SQ_STEPS].mw[MAG_W-1:0]);
            r4_y1  <= f_mul32(r_sd[SQ_STEPS].ay, r_sd[SQ_STEPS].mw[C_W-1:MAG_W]);
            r4_x0  <= f_mul32(r_sd[SQ_STEPS].ax, r_sd[SQ_STEPS].mw[MAG_W-1:0]);
            r4_x1  <= f_mul32(r_sd[SQ_STEPS].ax, r_sd[SQ_STEPS].mw[C_W-1:MAG_W]);
            r4_c   <= w_sq[SQ_STEPS].c;
            r4_s   <= w_sq[SQ_STEPS].root;
            r4_ax  <= r_sd[SQ_STEPS].ax;
            r4_ay  <= r_sd[SQ_STEPS].ay;
            r4_fl  <= r_sd[SQ_STEPS].fl;

            r5_den3 <= DEN3_W'(r4_p00) + (DEN3_W'(r4_p01) << MAG_W)
                     + (DEN3_W'(r4_p10) << MAG_W) + (DEN3_W'(r4_p11) << C_W);
            r5_ny   <= NY_W'(r4_y0) + (NY_W'(r4_y1) << MAG_W);
            r5_nx   <= NY_W'(r4_x0) + (NY_W'(r4_x1) << MAG_W);
            r5_c    <= r4_c;
            r5_s    <= r4_s;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_fl   <= r4_fl;

            r_fl[0] <= r5_fl;
            for (int k = 1; k <= QB; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    assign w_num_rpx = NUM_W'(r5_ax) << RSH;
    assign w_num_rpy = NUM_W'(r5_ay) << RSH;
    assign w_num_bpx = NUM_W'(r5_ay) << BSH;
    assign w_num_bpy = NUM_W'(r5_ax) << BSH;
    assign w_num_tpx = TNUM_W'(r5_ny) << RSH;
    assign w_num_tpy = TNUM_W'(r5_nx) << RSH;

    rmj_div_chain #(.DEN_W(C_W)) u_div_rpx (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_rpx), .i_den (r5_s),
        .o_quo (w_quo[E_RPX]), .o_ovf (w_ovf[E_RPX])
    );
    rmj_div_chain #(.DEN_W(C_W)) u_div_rpy (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_rpy), .i_den (r5_s),
        .o_quo (w_quo[E_RPY]), .o_ovf (w_ovf[E_RPY])
    );
    rmj_div_chain #(.DEN_W(C_W)) u_div_bpx (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_bpx), .i_den (r5_c),
        .o_quo (w_quo[E_BPX]), .o_ovf (w_ovf[E_BPX])
    );
    rmj_div_chain #(.DEN_W(C_W)) u_div_bpy (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_bpy), .i_den (r5_c),
        .o_quo (w_quo[E_BPY]), .o_ovf (w_ovf[E_BPY])
    );
    rmj_div_chain #(.DEN_W(DEN3_W)) u_div_tpx (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_tpx), .i_den (r5_den3),
        .o_quo (w_quo[E_TPX]), .o_ovf (w_ovf[E_TPX])
    );
    rmj_div_chain #(.DEN_W(DEN3_W)) u_div_tpy (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_num_tpy), .i_den (r5_den3),
        .o_quo (w_quo[E_TPY]), .o_ovf (w_ovf[E_TPY])
    );

    always_comb begin
        w_neg[E_RPX] = r_fl[QB].nx;
        w_neg[E_RPY] = r_fl[QB].ny;
        w_neg[E_BPX] = !r_fl[QB].ny;
        w_neg[E_BPY] = r_fl[QB].nx;
        w_neg[E_TPX] = r_fl[QB].ny ^ r_fl[QB].sw;
        w_neg[E_TPY] = r_fl[QB].nx ^ !r_fl[QB].sw;
        n_sat     = 1'b0;
        w_any_ovf = 1'b0;
        for (int e = 0; e < N_OUT; e++) begin
            w_pk[e]   = f_pack(w_neg[e], w_quo[e], w_ovf[e]);
            w_any_ovf = w_any_ovf | w_ovf[e];
            if (r_fl[QB].zero) begin
                n_out_data[e*FIELD_W +: FIELD_W] = '0;
            end else begin
                n_out_data[e*FIELD_W +: FIELD_W] = w_pk[e][FIELD_W-1:0];
                n_sat = n_sat | w_pk[e][FIELD_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data          <= n_out_data;
            r_out_user[TU_ZERO] <= r_fl[QB].zero;
            r_out_user[TU_SAT]  <= n_sat;
        end
    end

    assign w_rng_px = o_m_axis_tdata[FIELD_W-1:0];

    `RMJ_ASSERT_IMP(a_zero_clears, o_m_axis_tvalid && o_m_axis_tuser[TU_ZERO],
                    (o_m_axis_tdata == '0) && !o_m_axis_tuser[TU_SAT])
    `RMJ_ASSERT_IMP(a_range_unit, o_m_axis_tvalid && !o_m_axis_tuser[TU_ZERO],
                    (w_rng_px <= RNG_ONE) && (w_rng_px >= -RNG_ONE))
    `RMJ_ASSERT_IMP(a_root_rem, r_vld[V_SQ], w_sq[SQ_STEPS].rem <= w_root2)
    `RMJ_ASSERT_NXT(a_ovf_sat, w_en && r_vld[V_DIV] && !r_fl[QB].zero && w_any_ovf,
                    o_m_axis_tuser[TU_SAT])
endmodule
`default_nettype wire
